### rtl/core/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

    typedef logic [4:0][31:0] words5_t;

    localparam words5_t IV_WORDS = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [4:0] LAST_STEP = 5'd19;
    localparam logic [1:0] LAST_GROUP = 2'd3;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUTPUT
    } hsc_state_t;

    // One byte write into the block buffer.
    typedef struct packed {
        logic       we;
        logic [7:0] data;
        logic [5:0] pos;
    } hsc_wr_t;

    // Control of the round unit for one cycle.
    typedef struct packed {
        logic       load;
        logic       step;
        logic [4:0] idx;
        logic [1:0] grp;
    } hsc_rnd_ctrl_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [4:0] rot_a(input logic [4:0] idx);
        logic [4:0] r;
        unique case (idx)
            5'd0:    r = 5'd5;
            5'd1:    r = 5'd11;
            5'd2:    r = 5'd7;
            5'd3:    r = 5'd15;
            5'd4:    r = 5'd6;
            5'd5:    r = 5'd13;
            5'd6:    r = 5'd8;
            5'd7:    r = 5'd14;
            5'd8:    r = 5'd7;
            5'd9:    r = 5'd12;
            5'd10:   r = 5'd9;
            5'd11:   r = 5'd11;
            5'd12:   r = 5'd8;
            5'd13:   r = 5'd15;
            5'd14:   r = 5'd6;
            5'd15:   r = 5'd12;
            5'd16:   r = 5'd9;
            5'd17:   r = 5'd14;
            5'd18:   r = 5'd5;
            5'd19:   r = 5'd13;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rot_b(input logic [1:0] grp);
        logic [4:0] r;
        unique case (grp)
            2'd0: r = 5'd10;
            2'd1: r = 5'd17;
            2'd2: r = 5'd25;
            2'd3: r = 5'd30;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_const(input logic [1:0] grp);
        logic [31:0] k;
        unique case (grp)
            2'd0: k = 32'h00000000;
            2'd1: k = 32'h5a827999;
            2'd2: k = 32'h6ed9eba1;
            2'd3: k = 32'h8f1bbcdc;
        endcase
        return k;
    endfunction

    // Which extra word a finished message word is folded into.
    function automatic logic [1:0] extra_sel(input logic [3:0] k);
        logic [1:0] s;
        unique case (k)
            4'd0:  s = 2'd3;
            4'd1:  s = 2'd2;
            4'd2:  s = 2'd1;
            4'd3:  s = 2'd0;
            4'd4:  s = 2'd2;
            4'd5:  s = 2'd1;
            4'd6:  s = 2'd0;
            4'd7:  s = 2'd3;
            4'd8:  s = 2'd1;
            4'd9:  s = 2'd0;
            4'd10: s = 2'd3;
            4'd11: s = 2'd2;
            4'd12: s = 2'd0;
            4'd13: s = 2'd3;
            4'd14: s = 2'd2;
            4'd15: s = 2'd1;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/core/hsc_if.sv
`default_nettype none

interface hsc_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;
    logic       no_byte;

    modport source (output valid, output data_byte, output is_last, output no_byte,
                     input ready);
    modport sink (input valid, input data_byte, input is_last, input no_byte,
                  output ready);
endinterface

interface hsc_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

### rtl/core/hsc_msg_sched.sv
`default_nettype none

module hsc_msg_sched
    import hsc_pkg::*;
(
    input  wire logic        clk,
    input  wire hsc_wr_t     wr,
    input  wire logic [4:0]  rd_idx,
    output logic [31:0]      x_word
);

    logic [23:0]      acc_reg;
    logic [31:0]      word_mem [16];
    logic [3:0][31:0] extra_reg;
    logic [31:0]      full_word;
    logic [3:0]       word_idx;
    logic [1:0]       esel;

    assign full_word = {acc_reg, wr.data};
    assign word_idx  = wr.pos[5:2];
    assign esel      = extra_sel(word_idx);

    // Bytes are packed big-endian; each finished word also updates its extra word.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            acc_reg <= full_word[23:0];
            if (wr.pos[1:0] == 2'b11)
            begin
                word_mem[word_idx] <= full_word;
                if (word_idx < 4'd4)
                begin
                    extra_reg[esel] <= full_word;
                end
                else
                begin
                    extra_reg[esel] <= extra_reg[esel] ^ full_word;
                end
            end
        end
    end

    assign x_word = rd_idx[4] ? extra_reg[rd_idx[1:0]] : word_mem[rd_idx[3:0]];

endmodule

`default_nettype wire

### rtl/core/hsc_round_unit.sv
`default_nettype none

module hsc_round_unit
    import hsc_pkg::*;
(
    input  wire logic          clk,
    input  wire hsc_rnd_ctrl_t ctrl,
    input  wire words5_t       chain,
    input  wire logic [31:0]   x_word,
    output words5_t            work
);

    words5_t     work_reg;
    words5_t     work_next;
    logic [31:0] a, b, c, d, e;
    logic [31:0] f;
    logic [31:0] t;

    always_comb
    begin
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        d = work_reg[3];
        e = work_reg[4];
        unique case (ctrl.grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        t = rotl32(a, rot_a(ctrl.idx)) + f + e + x_word + round_const(ctrl.grp);

        priority if (ctrl.load)
        begin
            work_next = chain;
        end
        else if (ctrl.step)
        begin
            work_next[0] = t;
            work_next[1] = a;
            work_next[2] = rotl32(b, rot_b(ctrl.grp));
            work_next[3] = c;
            work_next[4] = d;
        end
        else
        begin
            work_next = work_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule

`default_nettype wire

### rtl/core/has160_style_hash_core.sv
// A message byte is written into the block buffer when taken; a byte that fills the
// block starts a compression (load, 80 rounds, chaining add). The last beat adds
// padding at one byte per cycle, one or two compressions, then five digest beats.
// Throughput is set by the single round unit: one round per cycle, 80 per 64-byte block.
// Reset (rst_n, asynchronous, active low) loads the initial chaining words and
// clears the byte count, block position and sequencer; buffer contents are undefined.
`default_nettype none

module has160_style_hash_core
    import hsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hsc_msg_if.sink   msg,
    hsc_dig_if.source dig
);

    // Sequencer state. The block takes one message beat at a time in IDLE.
    hsc_state_t    state_reg, state_next;
    logic [5:0]    pos_reg, pos_next;
    logic [60:0]   count_reg, count_next;
    logic [63:0]   len_reg, len_next;
    logic          first_reg, first_next;
    logic          len_ok_reg, len_ok_next;
    logic          len_done_reg, len_done_next;
    logic          fin_reg, fin_next;
    logic [4:0]    step_reg, step_next;
    logic [1:0]    grp_reg, grp_next;
    logic [2:0]    out_idx_reg, out_idx_next;
    words5_t       chain_reg, chain_next;

    hsc_wr_t       wr;
    hsc_rnd_ctrl_t rctrl;
    logic [31:0]   x_word;
    words5_t       work;

    hsc_msg_sched u_sched (
        .clk    (clk),
        .wr     (wr),
        .rd_idx (step_reg),
        .x_word (x_word)
    );

    hsc_round_unit u_round (
        .clk    (clk),
        .ctrl   (rctrl),
        .chain  (chain_reg),
        .x_word (x_word),
        .work   (work)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            first_reg    <= 1'b0;
            len_ok_reg   <= 1'b0;
            len_done_reg <= 1'b0;
            fin_reg      <= 1'b0;
            step_reg     <= '0;
            grp_reg      <= '0;
            out_idx_reg  <= '0;
            chain_reg    <= IV_WORDS;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            len_ok_reg   <= len_ok_next;
            len_done_reg <= len_done_next;
            fin_reg      <= fin_next;
            step_reg     <= step_next;
            grp_reg      <= grp_next;
            out_idx_reg  <= out_idx_next;
            chain_reg    <= chain_next;
        end
    end

    // The bit length is a payload register, reloaded on every accepted beat and shifted out while padding.
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        len_ok_next   = len_ok_reg;
        len_done_next = len_done_reg;
        fin_next      = fin_reg;
        step_next     = step_reg;
        grp_next      = grp_reg;
        out_idx_next  = out_idx_reg;
        chain_next    = chain_reg;

        wr.we      = 1'b0;
        wr.data    = msg.data_byte;
        wr.pos     = pos_reg;
        rctrl.load = 1'b0;
        rctrl.step = 1'b0;
        rctrl.idx  = step_reg;
        rctrl.grp  = grp_reg;

        msg.ready       = 1'b0;
        dig.valid       = 1'b0;
        dig.digest_word = chain_reg[out_idx_reg];
        dig.last_word   = (out_idx_reg == LAST_WORD_IDX);

        unique case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    // An item without a byte only matters when it closes the message.
                    count_next    = count_reg + {60'd0, ~msg.no_byte};
                    len_next      = {count_next, 3'b000};
                    fin_next      = msg.is_last;
                    first_next    = 1'b1;
                    len_ok_next   = 1'b0;
                    len_done_next = 1'b0;
                    if (!msg.no_byte)
                    begin
                        wr.we    = 1'b1;
                        pos_next = pos_reg + 6'd1;
                    end
                    if (!msg.no_byte && pos_reg == LAST_POS)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (msg.is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                // Marker byte first, then zeros; the length fills the tail of the
                // block once the marker has left room for it.
                wr.we      = 1'b1;
                pos_next   = pos_reg + 6'd1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    wr.data = PAD_MARK;
                    if (pos_reg < LEN_POS)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                else if (len_ok_reg && pos_reg >= LEN_POS)
                begin
                    wr.data  = len_reg[63:56];
                    len_next = {len_reg[55:0], 8'h00};
                end
                else
                begin
                    wr.data = 8'h00;
                end
                if (pos_reg == LAST_POS)
                begin
                    len_done_next = len_ok_reg;
                    len_ok_next   = 1'b1;
                    state_next    = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                rctrl.load = 1'b1;
                step_next  = '0;
                grp_next   = '0;
                state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                rctrl.step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next = '0;
                    grp_next  = grp_reg + 2'd1;
                    if (grp_reg == LAST_GROUP)
                    begin
                        state_next = ST_FOLD;
                    end
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            ST_FOLD:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    chain_next[k] = chain_reg[k] + work[k];
                end
                priority if (fin_reg && len_done_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUTPUT;
                end
                else if (fin_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUTPUT:
            begin
                dig.valid = 1'b1;
                if (dig.ready)
                begin
                    if (out_idx_reg == LAST_WORD_IDX)
                    begin
                        // Ready for a fresh message.
                        chain_next = IV_WORDS;
                        count_next = '0;
                        pos_next   = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The input side and the digest side are never open at once.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg.ready && dig.valid))
        else $error("message beat accepted while digest is pending");

    // After the final digest beat the chaining words are back at their start values.
    a_chain_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (dig.valid && dig.ready && dig.last_word) |=> (chain_reg == IV_WORDS))
        else $error("chaining words not restored after digest");

    // The eightieth round is followed by the chaining add.
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && step_reg == LAST_STEP && grp_reg == LAST_GROUP)
        |=> (state_reg == ST_FOLD))
        else $error("compression did not end after eighty rounds");

    // The digest index stays within the five chaining words.
    a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid |-> (out_idx_reg <= LAST_WORD_IDX))
        else $error("digest word index out of range");

endmodule

`default_nettype wire

### tb/has160_style_hash_core_tb.sv
module has160_style_hash_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // What a message beat carries, as the driver presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       skip;
    } msg_beat_t;

    // One expected digest beat.
    typedef struct packed {
        logic [31:0] word;
        logic        is_end;
    } digest_beat_t;

    // Byte patterns used to fill a message.
    typedef enum int {
        PAT_RANDOM,
        PAT_ONES,
        PAT_ZEROS
    } byte_pattern_t;

    // Hash constants, first entry first.
    localparam logic [0:4][31:0] CHAIN_INIT = {
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [0:3][31:0] GROUP_K = {
        32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc
    };
    localparam logic [0:19][4:0] ROT_A = {
        5'd5, 5'd11, 5'd7, 5'd15, 5'd6, 5'd13, 5'd8, 5'd14, 5'd7, 5'd12,
        5'd9, 5'd11, 5'd8, 5'd15, 5'd6, 5'd12, 5'd9, 5'd14, 5'd5, 5'd13
    };
    localparam logic [0:3][4:0] ROT_B = {5'd10, 5'd17, 5'd25, 5'd30};
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int RANDOM_ITEMS = 420;
    localparam int MIN_MESSAGES = 12;
    localparam int SHOW_LIMIT = 10;
    localparam int DRAIN_CYCLES = 300;

    logic clk;
    logic rst_n;

    hsc_msg_if msg_bus ();
    hsc_dig_if dig_bus ();

    has160_style_hash_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_bus),
        .dig   (dig_bus)
    );

    // Stimulus queue, filled up front and drained by the driver.
    msg_beat_t    pending_beats[$];
    // Digest beats the hash predictor has produced but the block has not yet sent.
    digest_beat_t expected_digest[$];

    // Predictor state: a private copy of the hash that tracks accepted beats.
    logic [7:0]       blk_bytes[64];
    logic [0:4][31:0] chain_acc;
    logic [60:0]      msg_len;
    int               fill_pos;

    int  fail_count;
    int  planned_items;
    int  message_total;
    bit  drive_on;
    bit  msg_took;
    int  burst_left;
    int  gap_left;
    int  rx_tick;
    msg_beat_t next_beat;

    // The clock runs from time zero with a 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // A generous ceiling on the whole run; a correct run ends far sooner.
    initial
    begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    // Run one 80-round compression over the current block and fold the
    // result into the chaining words. Words 16..19 are the XOR extension.
    task automatic run_compression();
        logic [31:0] m[20];
        logic [31:0] a, b, c, d, e, f, t;
        int i, g;
        for (int k = 0; k < 16; k++)
        begin
            m[k] = {blk_bytes[4*k], blk_bytes[4*k+1], blk_bytes[4*k+2], blk_bytes[4*k+3]};
        end
        m[16] = m[3] ^ m[6] ^ m[9] ^ m[12];
        m[17] = m[15] ^ m[2] ^ m[5] ^ m[8];
        m[18] = m[11] ^ m[14] ^ m[1] ^ m[4];
        m[19] = m[7] ^ m[10] ^ m[13] ^ m[0];
        a = chain_acc[0];
        b = chain_acc[1];
        c = chain_acc[2];
        d = chain_acc[3];
        e = chain_acc[4];
        for (int r = 0; r < 80; r++)
        begin
            i = r % 20;
            g = r / 20;
            if (g == 0)
                f = (b & c) | (~b & d);
            else if (g == 2)
                f = c ^ (b | ~d);
            else
                f = b ^ c ^ d;
            t = rol32(a, ROT_A[i]) + f + e + m[i] + GROUP_K[g];
            e = d;
            d = c;
            c = rol32(b, ROT_B[g]);
            b = a;
            a = t;
        end
        chain_acc[0] = chain_acc[0] + a;
        chain_acc[1] = chain_acc[1] + b;
        chain_acc[2] = chain_acc[2] + c;
        chain_acc[3] = chain_acc[3] + d;
        chain_acc[4] = chain_acc[4] + e;
    endtask

    // A byte enters the block; the 64th byte of a block triggers a compression.
    task automatic absorb_message_byte(input logic [7:0] value);
        blk_bytes[fill_pos] = value;
        fill_pos = fill_pos + 1;
        msg_len = msg_len + 61'd1;
        if (fill_pos == 64)
        begin
            run_compression();
            fill_pos = 0;
        end
    endtask

    // Pad the message, compress the tail (one or two blocks), queue the five
    // digest words and return to the start state for the next message.
    task automatic close_message();
        logic [63:0] bit_len;
        digest_beat_t beat;
        int p;
        bit_len = {msg_len, 3'b000};
        p = fill_pos;
        blk_bytes[p] = PAD_BYTE;
        for (int k = p + 1; k < 64; k++)
        begin
            blk_bytes[k] = 8'h00;
        end
        // No room left for the length: this block goes out with the pad only.
        if (p >= 56)
        begin
            run_compression();
            for (int k = 0; k < 64; k++)
            begin
                blk_bytes[k] = 8'h00;
            end
        end
        for (int k = 0; k < 8; k++)
        begin
            blk_bytes[63 - k] = bit_len[8*k +: 8];
        end
        run_compression();
        for (int k = 0; k < 5; k++)
        begin
            beat.word = chain_acc[k];
            beat.is_end = (k == 4);
            expected_digest.push_back(beat);
        end
        chain_acc = CHAIN_INIT;
        msg_len = '0;
        fill_pos = 0;
    endtask

    task automatic push_item(input logic [7:0] value, input logic is_end, input logic skip);
        msg_beat_t beat;
        beat.data = value;
        beat.is_end = is_end;
        beat.skip = skip;
        pending_beats.push_back(beat);
        // Beats the block ignores do not count toward the stimulus size.
        if (is_end || !skip)
            planned_items = planned_items + 1;
    endtask

    // Queue one whole message. It ends either on its final byte or on a
    // separate beat that carries no byte. Now and then an ignored beat is
    // slipped in between bytes.
    task automatic add_message(input int len, input byte_pattern_t pattern, input bit end_on_byte);
        logic [7:0] value;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            case (pattern)
                PAT_ONES:  value = 8'hff;
                PAT_ZEROS: value = 8'h00;
                default:   value = 8'($urandom_range(0, 255));
            endcase
            push_item(value, end_on_byte && (k == len - 1), 1'b0);
        end
        if (!end_on_byte || len == 0)
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        message_total = message_total + 1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < SHOW_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        fail_count = fail_count + 1;
    endtask

    // Monitor. At each rising edge it first notes whether a message beat was
    // taken and feeds it to the predictor, then checks any digest beat taken
    // at the same edge against the oldest expectation.
    always @(posedge clk)
    begin
        digest_beat_t want;
        if (!rst_n)
        begin
            msg_took = 1'b0;
        end
        else
        begin
            msg_took = msg_bus.valid && msg_bus.ready;
            if (msg_took)
            begin
                if (!msg_bus.no_byte)
                    absorb_message_byte(msg_bus.data_byte);
                if (msg_bus.is_last)
                    close_message();
            end
            if (dig_bus.valid && dig_bus.ready)
            begin
                if (expected_digest.size() == 0)
                begin
                    if (fail_count < SHOW_LIMIT)
                        $display("digest beat %h (last %b) with nothing expected",
                                 dig_bus.digest_word, dig_bus.last_word);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_digest.pop_front();
                    if (dig_bus.digest_word !== want.word)
                        report_mismatch("digest_word", want.word, dig_bus.digest_word);
                    if (dig_bus.last_word !== want.is_end)
                        report_mismatch("last_word", 32'(want.is_end), 32'(dig_bus.last_word));
                end
            end
        end
    end

    // Driver. Inputs change at the falling edge. A beat stays on the bus
    // until it is taken; the sender then works in bursts of random length
    // separated by random gaps, and about one burst in four runs with no gap.
    always @(negedge clk)
    begin
        if (!drive_on)
        begin
            msg_bus.valid <= 1'b0;
        end
        else if (msg_took || !msg_bus.valid)
        begin
            if (gap_left > 0 || pending_beats.size() == 0)
            begin
                msg_bus.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left = gap_left - 1;
            end
            else
            begin
                next_beat = pending_beats.pop_front();
                msg_bus.data_byte <= next_beat.data;
                msg_bus.is_last <= next_beat.is_end;
                msg_bus.no_byte <= next_beat.skip;
                msg_bus.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
        end
    end

    // Digest receiver. Its ready follows a slow four-phase pattern: always
    // ready, coin-flip stalls, rare stalls, and long stall stretches.
    always @(negedge clk)
    begin
        if (!drive_on)
        begin
            dig_bus.ready <= 1'b0;
        end
        else
        begin
            rx_tick = rx_tick + 1;
            case (rx_tick[9:8])
                2'd0: dig_bus.ready <= 1'b1;
                2'd1: dig_bus.ready <= ($urandom_range(0, 1) == 1);
                2'd2: dig_bus.ready <= ($urandom_range(0, 5) != 0);
                default: dig_bus.ready <= (rx_tick[4:0] < 5'd4);
            endcase
        end
    end

    initial
    begin
        int len;
        byte_pattern_t pattern;

        rst_n = 1'b0;
        drive_on = 1'b0;
        msg_took = 1'b0;
        fail_count = 0;
        planned_items = 0;
        message_total = 0;
        burst_left = 0;
        gap_left = 0;
        rx_tick = 0;
        msg_bus.valid = 1'b0;
        msg_bus.data_byte = 8'h00;
        msg_bus.is_last = 1'b0;
        msg_bus.no_byte = 1'b0;
        dig_bus.ready = 1'b0;
        chain_acc = CHAIN_INIT;
        msg_len = '0;
        fill_pos = 0;

        // Directed part: the empty message, ignored beats on their own,
        // single-byte messages at both byte extremes ending either on the
        // byte or on a separate end beat, and short three- and two-byte messages.
        add_message(0, PAT_RANDOM, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1);
        add_message(1, PAT_ZEROS, 1'b1);
        add_message(1, PAT_ONES, 1'b0);
        push_item(8'hff, 1'b0, 1'b1);
        add_message(3, PAT_RANDOM, 1'b1);
        add_message(2, PAT_RANDOM, 1'b0);

        // Random part: whole messages with random content. The lengths lean
        // toward the interesting edges: a block filled exactly, a tail that
        // leaves no room for the length field, and two full blocks.
        planned_items = 0;
        while (planned_items < RANDOM_ITEMS || message_total < MIN_MESSAGES)
        begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(55, 57);
                2: len = $urandom_range(63, 65);
                3: len = $urandom_range(119, 121);
                4: len = 64 * $urandom_range(1, 2);
                default: len = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 7))
                0: pattern = PAT_ONES;
                1: pattern = PAT_ZEROS;
                default: pattern = PAT_RANDOM;
            endcase
            add_message(len, pattern, $urandom_range(0, 1) == 1);
        end

        // Reset is held and then released at a falling edge; the
        // bus comes alive at the following rising edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        drive_on = 1'b1;

        // Wait until every beat has been taken and every digest word has
        // arrived, then idle a while so that stray beats are caught.
        while (pending_beats.size() != 0 || msg_bus.valid)
            @(posedge clk);
        while (expected_digest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
